[hw/rtl/cake_pkg.sv]
// ----------------------------------------------------------------------------
// cake_pkg
// Types, codes and field ranges shared by the clock and alarm key editor.
// ----------------------------------------------------------------------------
package cake_pkg;

	typedef enum logic [1:0] {
		REQ_KEY    = 2'd0,
		REQ_SAMPLE = 2'd1,
		REQ_TICK   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		KEY_NONE = 3'd0,
		KEY_MODE = 3'd1,
		KEY_SET  = 3'd2,
		KEY_ADD  = 3'd3,
		KEY_SUB  = 3'd4
	} key_t;

	typedef enum logic [1:0] {
		WK_NONE     = 2'd0,
		WK_TIME     = 2'd1,
		WK_TIMEDATE = 2'd2,
		WK_ALARM    = 2'd3
	} wk_t;

	typedef enum logic [2:0] {
		FLD_HOUR    = 3'd0,
		FLD_MINUTE  = 3'd1,
		FLD_SECOND  = 3'd2,
		FLD_WEEKDAY = 3'd3,
		FLD_YEAR    = 3'd4,
		FLD_MONTH   = 3'd5,
		FLD_DAY     = 3'd6,
		FLD_NONE    = 3'd7
	} field_t;

	localparam logic signed [3:0] CUR_NONE = -4'sd1;
	localparam logic signed [4:0] CLOCK_FIELDS = 5'sd7;
	localparam logic signed [4:0] ALARM_FIELDS = 5'sd4;

	localparam logic [6:0] HOUR_MAX  = 7'd23;
	localparam logic [6:0] MIN_MAX   = 7'd59;
	localparam logic [6:0] YEAR_MAX  = 7'd99;
	localparam logic [6:0] MONTH_MAX = 7'd12;
	localparam logic [6:0] DAY_MAX   = 7'd31;
	localparam logic [6:0] ZERO_MIN  = 7'd0;
	localparam logic [6:0] ONE_MIN   = 7'd1;

	localparam logic [4:0] ALARM_HOUR_RST    = 5'd8;
	localparam logic [5:0] ALARM_MINUTE_RST  = 6'd29;
	localparam logic [5:0] ALARM_SECOND_RST  = 6'd50;
	localparam logic [2:0] ALARM_WEEKDAY_RST = 3'd4;

	// Input item as held in the input register (tuser and tdata unpacked).
	typedef struct packed {
		logic [1:0] req;
		logic [2:0] key;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [2:0] weekday;
	} in_item_t;

	// Weekday step forward: seven and the unused zero code both land on Monday.
	function automatic logic [2:0] weekday_inc(input logic [2:0] w);
		logic [2:0] r;
		case (w)
			3'd0: r = 3'd1;
			3'd1: r = 3'd2;
			3'd2: r = 3'd3;
			3'd3: r = 3'd4;
			3'd4: r = 3'd5;
			3'd5: r = 3'd6;
			3'd6: r = 3'd7;
			default: r = 3'd1;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] weekday_dec(input logic [2:0] w);
		logic [2:0] r;
		case (w)
			3'd0: r = 3'd6;
			3'd1: r = 3'd7;
			3'd2: r = 3'd1;
			3'd3: r = 3'd2;
			3'd4: r = 3'd3;
			3'd5: r = 3'd4;
			3'd6: r = 3'd5;
			default: r = 3'd6;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/clock_alarm_key_editor_unit.sv]
// ----------------------------------------------------------------------------
// clock_alarm_key_editor_unit
// Key-driven clock and alarm setting controller with display and write output.
// ----------------------------------------------------------------------------
// Each input item is a key event, a live RTC sample or a blink tick, chosen by
// s_tuser. Every item gives exactly one result item: the values to show, the
// field under the cursor and whether it is blanked, and a write command for the
// RTC or the alarm in m_tuser. An item is taken into an input register, and the
// state update and result are formed in one pass into the output register, so a
// new item is accepted in every cycle unless the input register is full and a
// waiting result is not taken; the output register lets the next item enter
// while the previous result is still waiting to be taken.
module clock_alarm_key_editor_unit import cake_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// key[2:0], rtc_hour[7:3], rtc_minute[13:8], rtc_second[19:14],
	// rtc_yr[26:20], rtc_mon[30:27], rtc_day[35:31], rtc_weekday[38:36], zero[39]
	input  logic [39:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// shown_mode[0], cursor_field[4:1], blank_cursor[5], out_hour[10:6],
	// out_minute[16:11], out_second[22:17], out_year[29:23], out_month[33:30],
	// out_day[38:34], out_weekday[41:39], zero[47:42]
	output logic [47:0] m_tdata,
	// write_kind[1:0]
	output logic [1:0]  m_tuser
);

	in_item_t item_s1;
	logic     valid_s1;
	logic     adv;

	logic              alarm_mode_q, editing_q, blink_run_q, blink_phase_q;
	logic signed [3:0] cursor_q;
	logic [4:0] edit_hour_q, live_hour_q, edit_day_q, live_day_q, alarm_hour_q;
	logic [5:0] edit_minute_q, live_minute_q, live_second_q, alarm_minute_q, alarm_second_q;
	logic [6:0] edit_year_q, live_year_q;
	logic [3:0] edit_month_q, live_month_q;
	logic [2:0] edit_weekday_q, live_weekday_q, alarm_weekday_q;

	logic              n_alarm_mode, n_editing, n_blink_run, n_blink_phase;
	logic signed [3:0] n_cursor;
	logic [4:0] n_edit_hour, n_live_hour, n_edit_day, n_live_day, n_alarm_hour;
	logic [5:0] n_edit_minute, n_live_minute, n_live_second, n_alarm_minute, n_alarm_second;
	logic [6:0] n_edit_year, n_live_year;
	logic [3:0] n_edit_month, n_live_month;
	logic [2:0] n_edit_weekday, n_live_weekday, n_alarm_weekday;
	wk_t        wk;

	logic signed [4:0] next_cur;
	logic signed [4:0] field_count;
	field_t            fld;
	logic [6:0]        fld_val;
	logic [6:0]        adj_val;

	logic [4:0] r_hour, r_day;
	logic [5:0] r_minute, r_second;
	logic [6:0] r_year;
	logic [3:0] r_month;
	logic [2:0] r_weekday;
	logic       r_blank;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{req: s_tuser, key: s_tdata[2:0], hour: s_tdata[7:3],
				minute: s_tdata[13:8], second: s_tdata[19:14], year: s_tdata[26:20],
				month: s_tdata[30:27], day: s_tdata[35:31], weekday: s_tdata[38:36]};
		end
	end

	// Cursor picks edit copies (live seconds) in clock mode, alarm values in alarm mode.
	always_comb begin
		if (cursor_q == CUR_NONE || (alarm_mode_q && cursor_q > 4'sd3)) begin
			fld = FLD_NONE;
		end else begin
			fld = field_t'(cursor_q[2:0]);
		end
	end

	always_comb begin
		case (fld)
			FLD_HOUR:    fld_val = {2'd0, alarm_mode_q ? alarm_hour_q : edit_hour_q};
			FLD_MINUTE:  fld_val = {1'b0, alarm_mode_q ? alarm_minute_q : edit_minute_q};
			FLD_SECOND:  fld_val = {1'b0, alarm_mode_q ? alarm_second_q : live_second_q};
			FLD_WEEKDAY: fld_val = {4'd0, alarm_mode_q ? alarm_weekday_q : edit_weekday_q};
			FLD_YEAR:    fld_val = edit_year_q;
			FLD_MONTH:   fld_val = {3'd0, edit_month_q};
			FLD_DAY:     fld_val = {2'd0, edit_day_q};
			default:     fld_val = 7'd0;
		endcase
	end

	cake_field_adjust u_adjust (
		.field     (fld),
		.up        (item_s1.key == KEY_ADD),
		.value_in  (fld_val),
		.value_out (adj_val)
	);

	assign next_cur    = {cursor_q[3], cursor_q} + 5'sd1;
	assign field_count = alarm_mode_q ? ALARM_FIELDS : CLOCK_FIELDS;

	always_comb begin
		n_alarm_mode    = alarm_mode_q;
		n_editing       = editing_q;
		n_blink_run     = blink_run_q;
		n_blink_phase   = blink_phase_q;
		n_cursor        = cursor_q;
		n_edit_hour     = edit_hour_q;
		n_edit_minute   = edit_minute_q;
		n_edit_year     = edit_year_q;
		n_edit_month    = edit_month_q;
		n_edit_day      = edit_day_q;
		n_edit_weekday  = edit_weekday_q;
		n_live_hour     = live_hour_q;
		n_live_minute   = live_minute_q;
		n_live_second   = live_second_q;
		n_live_year     = live_year_q;
		n_live_month    = live_month_q;
		n_live_day      = live_day_q;
		n_live_weekday  = live_weekday_q;
		n_alarm_hour    = alarm_hour_q;
		n_alarm_minute  = alarm_minute_q;
		n_alarm_second  = alarm_second_q;
		n_alarm_weekday = alarm_weekday_q;
		wk              = WK_NONE;
		case (req_t'(item_s1.req))
			REQ_SAMPLE: begin
				n_live_hour    = item_s1.hour;
				n_live_minute  = item_s1.minute;
				n_live_second  = item_s1.second;
				n_live_year    = item_s1.year;
				n_live_month   = item_s1.month;
				n_live_day     = item_s1.day;
				n_live_weekday = item_s1.weekday;
			end
			REQ_TICK: begin
				if (blink_run_q) begin
					n_blink_phase = !blink_phase_q;
				end
			end
			REQ_KEY: begin
				case (key_t'(item_s1.key))
					KEY_MODE: begin
						n_editing    = 1'b0;
						n_cursor     = CUR_NONE;
						n_alarm_mode = !alarm_mode_q;
					end
					KEY_SET: begin
						if (next_cur >= field_count || next_cur < 5'sd0) begin
							// Leaving the last field commits what was edited.
							n_blink_run = 1'b0;
							n_cursor    = CUR_NONE;
							if (alarm_mode_q) begin
								wk = WK_ALARM;
							end else begin
								n_editing = 1'b0;
								wk        = WK_TIMEDATE;
							end
						end else begin
							n_blink_run = 1'b1;
							n_cursor    = next_cur[3:0];
							if (!alarm_mode_q && cursor_q == CUR_NONE) begin
								n_editing      = 1'b1;
								n_edit_hour    = live_hour_q;
								n_edit_minute  = live_minute_q;
								n_edit_year    = live_year_q;
								n_edit_month   = live_month_q;
								n_edit_day     = live_day_q;
								n_edit_weekday = live_weekday_q;
							end
						end
					end
					KEY_ADD, KEY_SUB: begin
						case (fld)
							FLD_HOUR: begin
								if (alarm_mode_q) n_alarm_hour = adj_val[4:0];
								else n_edit_hour = adj_val[4:0];
							end
							FLD_MINUTE: begin
								if (alarm_mode_q) n_alarm_minute = adj_val[5:0];
								else n_edit_minute = adj_val[5:0];
							end
							FLD_SECOND: begin
								if (alarm_mode_q) n_alarm_second = adj_val[5:0];
								else n_live_second = adj_val[5:0];
							end
							FLD_WEEKDAY: begin
								if (alarm_mode_q) n_alarm_weekday = adj_val[2:0];
								else n_edit_weekday = adj_val[2:0];
							end
							FLD_YEAR:  n_edit_year  = adj_val;
							FLD_MONTH: n_edit_month = adj_val[3:0];
							FLD_DAY:   n_edit_day   = adj_val[4:0];
							default: ;
						endcase
						if (item_s1.key == KEY_SUB && cursor_q == 4'sd2) begin
							wk = WK_TIME;
						end
						n_blink_run   = 1'b0;
						n_blink_phase = 1'b0;
					end
					KEY_NONE: begin
						if (cursor_q != CUR_NONE && !blink_run_q) begin
							n_blink_run = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Result fields, taken from the state after this item's update.
	always_comb begin
		if (n_alarm_mode) begin
			r_hour    = n_alarm_hour;
			r_minute  = n_alarm_minute;
			r_second  = n_alarm_second;
			r_year    = 7'd0;
			r_month   = 4'd0;
			r_day     = 5'd0;
			r_weekday = n_alarm_weekday;
		end else begin
			r_hour    = n_editing ? n_edit_hour : n_live_hour;
			r_minute  = n_editing ? n_edit_minute : n_live_minute;
			r_second  = n_live_second;
			r_year    = n_editing ? n_edit_year : n_live_year;
			r_month   = n_editing ? n_edit_month : n_live_month;
			r_day     = n_editing ? n_edit_day : n_live_day;
			r_weekday = n_editing ? n_edit_weekday : n_live_weekday;
		end
		case (wk)
			WK_TIME, WK_TIMEDATE: begin
				r_hour   = n_edit_hour;
				r_minute = n_edit_minute;
				r_second = n_live_second;
				if (wk == WK_TIMEDATE) begin
					r_year    = n_edit_year;
					r_month   = n_edit_month;
					r_day     = n_edit_day;
					r_weekday = n_edit_weekday;
				end
			end
			WK_ALARM: begin
				r_hour    = n_alarm_hour;
				r_minute  = n_alarm_minute;
				r_second  = n_alarm_second;
				r_weekday = n_alarm_weekday;
			end
			default: ;
		endcase
		r_blank = (n_cursor != CUR_NONE) && n_blink_phase;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_mode_q    <= 1'b0;
			editing_q       <= 1'b0;
			blink_run_q     <= 1'b0;
			blink_phase_q   <= 1'b0;
			cursor_q        <= CUR_NONE;
			edit_hour_q     <= '0;
			edit_minute_q   <= '0;
			edit_year_q     <= '0;
			edit_month_q    <= '0;
			edit_day_q      <= '0;
			edit_weekday_q  <= '0;
			live_hour_q     <= '0;
			live_minute_q   <= '0;
			live_second_q   <= '0;
			live_year_q     <= '0;
			live_month_q    <= '0;
			live_day_q      <= '0;
			live_weekday_q  <= '0;
			alarm_hour_q    <= ALARM_HOUR_RST;
			alarm_minute_q  <= ALARM_MINUTE_RST;
			alarm_second_q  <= ALARM_SECOND_RST;
			alarm_weekday_q <= ALARM_WEEKDAY_RST;
			m_tvalid        <= 1'b0;
		end else begin
			if (adv) begin
				alarm_mode_q    <= n_alarm_mode;
				editing_q       <= n_editing;
				blink_run_q     <= n_blink_run;
				blink_phase_q   <= n_blink_phase;
				cursor_q        <= n_cursor;
				edit_hour_q     <= n_edit_hour;
				edit_minute_q   <= n_edit_minute;
				edit_year_q     <= n_edit_year;
				edit_month_q    <= n_edit_month;
				edit_day_q      <= n_edit_day;
				edit_weekday_q  <= n_edit_weekday;
				live_hour_q     <= n_live_hour;
				live_minute_q   <= n_live_minute;
				live_second_q   <= n_live_second;
				live_year_q     <= n_live_year;
				live_month_q    <= n_live_month;
				live_day_q      <= n_live_day;
				live_weekday_q  <= n_live_weekday;
				alarm_hour_q    <= n_alarm_hour;
				alarm_minute_q  <= n_alarm_minute;
				alarm_second_q  <= n_alarm_second;
				alarm_weekday_q <= n_alarm_weekday;
				m_tvalid        <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {6'd0, r_weekday, r_day, r_month, r_year, r_second, r_minute,
				r_hour, r_blank, n_cursor, n_alarm_mode};
			m_tuser <= wk;
		end
	end

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a blocked result");

	a_blank_needs_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> m_tdata[4:1] != 4'hF)
		else $error("blanked field reported with no cursor");

	a_write_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == WK_ALARM || m_tuser == WK_TIMEDATE)
		|-> m_tdata[0] == (m_tuser == WK_ALARM))
		else $error("commit write does not match the shown mode");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q >= CUR_NONE && cursor_q < (alarm_mode_q ? 4'sd4 : 4'sd7))
		else $error("cursor outside the fields of the current mode");
`endif

endmodule

[hw/rtl/cake_field_adjust.sv]
// ----------------------------------------------------------------------------
// cake_field_adjust
// Steps one time or date field up or down, wrapping within its range.
// ----------------------------------------------------------------------------
module cake_field_adjust import cake_pkg::*; (
	input  field_t     field,
	input  logic       up,
	input  logic [6:0] value_in,
	output logic [6:0] value_out
);

	logic [6:0] lo;
	logic [6:0] hi;
	logic [6:0] wrapped;

	always_comb begin
		case (field)
			FLD_HOUR: begin
				lo = ZERO_MIN;
				hi = HOUR_MAX;
			end
			FLD_MINUTE, FLD_SECOND: begin
				lo = ZERO_MIN;
				hi = MIN_MAX;
			end
			FLD_YEAR: begin
				lo = ZERO_MIN;
				hi = YEAR_MAX;
			end
			FLD_MONTH: begin
				lo = ONE_MIN;
				hi = MONTH_MAX;
			end
			FLD_DAY: begin
				lo = ONE_MIN;
				hi = DAY_MAX;
			end
			default: begin
				lo = ZERO_MIN;
				hi = ZERO_MIN;
			end
		endcase
	end

	// Out-of-range values go to the top on a step down, and to the bottom on a step up.
	always_comb begin
		if (up) begin
			wrapped = (value_in >= hi) ? lo : value_in + 7'd1;
		end else begin
			wrapped = (value_in <= lo || value_in > hi) ? hi : value_in - 7'd1;
		end
	end

	always_comb begin
		case (field)
			FLD_WEEKDAY: begin
				value_out = {4'd0, up ? weekday_inc(value_in[2:0]) : weekday_dec(value_in[2:0])};
			end
			FLD_NONE: begin
				value_out = value_in;
			end
			default: begin
				value_out = wrapped;
			end
		endcase
	end

endmodule

[verif/tb_clock_alarm_key_editor_unit.sv]
// ----------------------------------------------------------------------------
// tb_clock_alarm_key_editor_unit
// Self-checking testbench for the clock and alarm key editor.
// ----------------------------------------------------------------------------
// Key events, RTC samples and blink ticks go in as stream items. A behavioural
// copy of the editor works out the display and write command that each item
// should give. Results are compared field by field, in order. Both sides of
// the block idle at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb_clock_alarm_key_editor_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import cake_pkg::*;

	localparam int RESET_CYCLES = 12;
	localparam int MAX_WAIT     = 17;
	localparam int RANDOM_ITEMS = 1200;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_LIMIT = 10;
	localparam int NO_CURSOR    = int'(CUR_NONE);
	localparam logic [2:0] KEY_SPARE   = 3'd5;
	localparam logic [2:0] WEEKDAY_TOP = 3'd7;

	// Result item laid out as on m_tdata, lowest field last.
	typedef struct packed {
		logic [5:0]        pad;
		logic [2:0]        weekday;
		logic [4:0]        day;
		logic [3:0]        month;
		logic [6:0]        year;
		logic [5:0]        second;
		logic [5:0]        minute;
		logic [4:0]        hour;
		logic              blank;
		logic signed [3:0] cursor;
		logic              mode;
	} display_t;

	typedef struct packed {
		wk_t      kind;
		display_t disp;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	result_t owed_results[$];
	int      mismatches = 0;
	int      items_sent = 0;
	int      cycles = 0;
	bit      send_burst = 1'b0;
	bit      take_burst = 1'b0;

	// Editor state as the block should hold it.
	bit       in_alarm = 1'b0;
	int       cur = NO_CURSOR;
	bit       editing = 1'b0;
	bit       blink_on = 1'b0;
	bit       blink_phase = 1'b0;
	logic [4:0] ed_hour = '0;
	logic [5:0] ed_minute = '0;
	logic [6:0] ed_year = '0;
	logic [3:0] ed_month = '0;
	logic [4:0] ed_day = '0;
	logic [2:0] ed_weekday = '0;
	logic [4:0] rt_hour = '0;
	logic [5:0] rt_minute = '0;
	logic [5:0] rt_second = '0;
	logic [6:0] rt_year = '0;
	logic [3:0] rt_month = '0;
	logic [4:0] rt_day = '0;
	logic [2:0] rt_weekday = '0;
	logic [4:0] al_hour = ALARM_HOUR_RST;
	logic [5:0] al_minute = ALARM_MINUTE_RST;
	logic [5:0] al_second = ALARM_SECOND_RST;
	logic [2:0] al_weekday = ALARM_WEEKDAY_RST;

	clock_alarm_key_editor_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results owed", cycles, owed_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int step_up(int v, int lo, int hi);
		return (v >= hi) ? lo : v + 1;
	endfunction

	function automatic int step_down(int v, int lo, int hi);
		return (v <= lo || v > hi) ? hi : v - 1;
	endfunction

	function automatic int nudge(int fld, int v, bit up);
		int r;
		r = v;
		case (fld)
			FLD_HOUR: r = up ? step_up(v, ZERO_MIN, HOUR_MAX) : step_down(v, ZERO_MIN, HOUR_MAX);
			FLD_MINUTE, FLD_SECOND: begin
				r = up ? step_up(v, ZERO_MIN, MIN_MAX) : step_down(v, ZERO_MIN, MIN_MAX);
			end
			FLD_WEEKDAY: r = up ? (v % 7) + 1 : ((v + 5) % 7) + 1;
			FLD_YEAR: r = up ? step_up(v, ZERO_MIN, YEAR_MAX) : step_down(v, ZERO_MIN, YEAR_MAX);
			FLD_MONTH: r = up ? step_up(v, ONE_MIN, MONTH_MAX) : step_down(v, ONE_MIN, MONTH_MAX);
			FLD_DAY: r = up ? step_up(v, ONE_MIN, DAY_MAX) : step_down(v, ONE_MIN, DAY_MAX);
			default: r = v;
		endcase
		return r;
	endfunction

	task automatic adjust_cursor_field(input bit up);
		if (in_alarm) begin
			case (cur)
				FLD_HOUR: al_hour = 5'(nudge(cur, al_hour, up));
				FLD_MINUTE: al_minute = 6'(nudge(cur, al_minute, up));
				FLD_SECOND: al_second = 6'(nudge(cur, al_second, up));
				FLD_WEEKDAY: al_weekday = 3'(nudge(cur, al_weekday, up));
				default: ;
			endcase
		end else begin
			// The seconds field is edited in the live copy, not an edit copy.
			case (cur)
				FLD_HOUR: ed_hour = 5'(nudge(cur, ed_hour, up));
				FLD_MINUTE: ed_minute = 6'(nudge(cur, ed_minute, up));
				FLD_SECOND: rt_second = 6'(nudge(cur, rt_second, up));
				FLD_WEEKDAY: ed_weekday = 3'(nudge(cur, ed_weekday, up));
				FLD_YEAR: ed_year = 7'(nudge(cur, ed_year, up));
				FLD_MONTH: ed_month = 4'(nudge(cur, ed_month, up));
				FLD_DAY: ed_day = 5'(nudge(cur, ed_day, up));
				default: ;
			endcase
		end
	endtask

	// Applies one accepted item to the editor state and queues the result owed.
	task automatic advance_editor(input in_item_t it);
		wk_t     kind;
		int      nxt;
		result_t r;
		kind = WK_NONE;
		case (it.req)
			REQ_SAMPLE: begin
				rt_hour = it.hour;
				rt_minute = it.minute;
				rt_second = it.second;
				rt_year = it.year;
				rt_month = it.month;
				rt_day = it.day;
				rt_weekday = it.weekday;
			end
			REQ_TICK: begin
				if (blink_on)
					blink_phase = !blink_phase;
			end
			REQ_KEY: begin
				case (it.key)
					KEY_MODE: begin
						editing = 1'b0;
						cur = NO_CURSOR;
						in_alarm = !in_alarm;
					end
					KEY_SET: begin
						nxt = cur + 1;
						if (nxt >= int'(in_alarm ? ALARM_FIELDS : CLOCK_FIELDS)) begin
							blink_on = 1'b0;
							nxt = NO_CURSOR;
							if (in_alarm) begin
								kind = WK_ALARM;
							end else begin
								editing = 1'b0;
								kind = WK_TIMEDATE;
							end
						end else begin
							blink_on = 1'b1;
							if (!in_alarm && cur == NO_CURSOR) begin
								editing = 1'b1;
								ed_hour = rt_hour;
								ed_minute = rt_minute;
								ed_year = rt_year;
								ed_month = rt_month;
								ed_day = rt_day;
								ed_weekday = rt_weekday;
							end
						end
						cur = nxt;
					end
					KEY_ADD, KEY_SUB: begin
						adjust_cursor_field(it.key == KEY_ADD);
						if (it.key == KEY_SUB && cur == FLD_SECOND)
							kind = WK_TIME;
						blink_on = 1'b0;
						blink_phase = 1'b0;
					end
					KEY_NONE: begin
						if (cur != NO_CURSOR && !blink_on)
							blink_on = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		r = '0;
		r.kind = kind;
		r.disp.mode = in_alarm;
		r.disp.cursor = 4'(cur);
		r.disp.blank = (cur != NO_CURSOR) && blink_phase;
		if (in_alarm) begin
			r.disp.hour = al_hour;
			r.disp.minute = al_minute;
			r.disp.second = al_second;
			r.disp.weekday = al_weekday;
		end else begin
			r.disp.hour = editing ? ed_hour : rt_hour;
			r.disp.minute = editing ? ed_minute : rt_minute;
			r.disp.second = rt_second;
			r.disp.year = editing ? ed_year : rt_year;
			r.disp.month = editing ? ed_month : rt_month;
			r.disp.day = editing ? ed_day : rt_day;
			r.disp.weekday = editing ? ed_weekday : rt_weekday;
		end
		if (kind == WK_TIME || kind == WK_TIMEDATE) begin
			r.disp.hour = ed_hour;
			r.disp.minute = ed_minute;
			r.disp.second = rt_second;
			if (kind == WK_TIMEDATE) begin
				r.disp.year = ed_year;
				r.disp.month = ed_month;
				r.disp.day = ed_day;
				r.disp.weekday = ed_weekday;
			end
		end else if (kind == WK_ALARM) begin
			r.disp.hour = al_hour;
			r.disp.minute = al_minute;
			r.disp.second = al_second;
			r.disp.weekday = al_weekday;
		end
		owed_results.push_back(r);
	endtask

	function automatic int pick(int lo, int hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	function automatic logic [2:0] any_key();
		return 3'($urandom_range(KEY_NONE, KEY_SPARE));
	endfunction

	// RTC fields are random in every item so that their bits move even when unused.
	function automatic in_item_t make_item(input req_t req, input logic [2:0] key);
		in_item_t it;
		it.req = req;
		it.key = key;
		it.hour = 5'(pick(0, HOUR_MAX));
		it.minute = 6'(pick(0, MIN_MAX));
		it.second = 6'(pick(0, MIN_MAX));
		it.year = 7'(pick(0, YEAR_MAX));
		it.month = 4'(pick(0, MONTH_MAX));
		it.day = 5'(pick(0, DAY_MAX));
		it.weekday = 3'(pick(0, WEEKDAY_TOP));
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.req;
		s_tdata <= {1'b0, it.weekday, it.day, it.month, it.year, it.second, it.minute,
			it.hour, it.key};
		do @(posedge clk); while (!s_tready);
		advance_editor(it);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got)
			note_mismatch($sformatf("%s expected %0d, got %0d", what, want, got));
	endfunction

	function automatic void check_result(input result_t got);
		result_t want;
		if (owed_results.size() == 0) begin
			note_mismatch($sformatf("result item with none owed, m_tdata %h", got.disp));
			return;
		end
		want = owed_results.pop_front();
		check_field("shown_mode", want.disp.mode, got.disp.mode);
		check_field("cursor_field", int'(want.disp.cursor), int'(got.disp.cursor));
		check_field("blank_cursor", want.disp.blank, got.disp.blank);
		check_field("out_hour", want.disp.hour, got.disp.hour);
		check_field("out_minute", want.disp.minute, got.disp.minute);
		check_field("out_second", want.disp.second, got.disp.second);
		check_field("out_year", want.disp.year, got.disp.year);
		check_field("out_month", want.disp.month, got.disp.month);
		check_field("out_day", want.disp.day, got.disp.day);
		check_field("out_weekday", want.disp.weekday, got.disp.weekday);
		check_field("m_tdata padding", want.disp.pad, got.disp.pad);
		check_field("write_kind", want.kind, got.kind);
	endfunction

	initial begin : result_checker
		result_t got;
		int      stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				take_burst = !take_burst;
			stall = take_burst ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.kind = wk_t'(m_tuser);
			got.disp = m_tdata;
			check_result(got);
			@(negedge clk);
		end
	end

	task automatic test_reset_display();
		// The blink is stopped after reset, so a tick must not blank anything.
		send_item(make_item(REQ_TICK, any_key()));
	endtask

	task automatic test_clock_edit();
		in_item_t it;
		it = make_item(REQ_SAMPLE, KEY_NONE);
		it.hour = 5'(HOUR_MAX);
		it.minute = 6'(MIN_MAX);
		it.second = 6'(MIN_MAX);
		it.year = YEAR_MAX;
		it.month = 4'(MONTH_MAX);
		it.day = 5'(DAY_MAX);
		it.weekday = WEEKDAY_TOP;
		send_item(it);
		send_item(make_item(REQ_KEY, KEY_SET));
		send_item(make_item(REQ_KEY, KEY_ADD));
		repeat (2) send_item(make_item(REQ_KEY, KEY_SET));
		// Sub on the seconds field writes the time straight away.
		send_item(make_item(REQ_KEY, KEY_SUB));
		send_item(make_item(REQ_KEY, KEY_SET));
		send_item(make_item(REQ_KEY, KEY_ADD));
		send_item(make_item(REQ_KEY, KEY_SET));
		send_item(make_item(REQ_KEY, KEY_SUB));
		// Month, day, then past the last field to commit time and date.
		repeat (3) send_item(make_item(REQ_KEY, KEY_SET));
	endtask

	task automatic test_alarm_edit();
		send_item(make_item(REQ_KEY, KEY_MODE));
		repeat (3) send_item(make_item(REQ_KEY, KEY_SET));
		// A time write is still made from the alarm screen.
		send_item(make_item(REQ_KEY, KEY_SUB));
		send_item(make_item(REQ_KEY, KEY_SET));
		send_item(make_item(REQ_KEY, KEY_SUB));
		send_item(make_item(REQ_KEY, KEY_SET));
	endtask

	task automatic test_blink_and_idle_keys();
		send_item(make_item(REQ_KEY, KEY_SET));
		send_item(make_item(REQ_TICK, any_key()));
		send_item(make_item(REQ_KEY, KEY_ADD));
		send_item(make_item(REQ_KEY, KEY_NONE));
		send_item(make_item(REQ_KEY, KEY_MODE));
		// With no cursor, add only pauses the blink.
		send_item(make_item(REQ_KEY, KEY_ADD));
		send_item(make_item(REQ_KEY, KEY_SPARE));
	endtask

	task automatic test_random_sessions();
		int       stop_at;
		int       steps;
		int       roll;
		in_item_t it;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 9) < 3) begin
				repeat ($urandom_range(1, 6))
					send_item(make_item(req_t'($urandom_range(REQ_KEY, REQ_TICK)), any_key()));
			end else begin
				if ($urandom_range(0, 3) == 0)
					send_item(make_item(REQ_KEY, KEY_MODE));
				if ($urandom_range(0, 2) == 0)
					send_item(make_item(REQ_SAMPLE, any_key()));
				// Most sessions step through to the commit; a few are cut short.
				steps = int'(in_alarm ? ALARM_FIELDS : CLOCK_FIELDS) - cur;
				if ($urandom_range(0, 5) == 0)
					steps = $urandom_range(1, steps);
				repeat (steps) begin
					send_item(make_item(REQ_KEY, KEY_SET));
					repeat ($urandom_range(0, 4)) begin
						roll = $urandom_range(0, 19);
						if (roll < 7)
							it = make_item(REQ_KEY, KEY_ADD);
						else if (roll < 14)
							it = make_item(REQ_KEY, KEY_SUB);
						else if (roll < 16)
							it = make_item(REQ_KEY, KEY_NONE);
						else if (roll < 18)
							it = make_item(REQ_TICK, any_key());
						else
							it = make_item(REQ_SAMPLE, any_key());
						send_item(it);
					end
				end
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_display();
		test_clock_edit();
		test_alarm_edit();
		test_blink_and_idle_keys();
		test_random_sessions();
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
